[hw/rtl/lcfp_pkg.sv]
// lcfp_pkg: shared types, codes and command text for the line command frame parser
// no dependencies; imported by lcfp_core, lcfp_out_buf and line_command_frame_parser_top
package lcfp_pkg;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TIME  = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;

  localparam logic [2:0] CODE_MANUAL = 3'd0;
  localparam logic [2:0] CODE_AUTO   = 3'd1;
  localparam logic [2:0] CODE_PAUSE  = 3'd2;
  localparam logic [2:0] CODE_ESTOP  = 3'd4;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_C     = "C";
  localparam logic [7:0] CHAR_S     = "S";
  localparam logic [7:0] CHAR_COLON = ":";
  localparam logic [7:0] CHAR_ZERO  = "0";
  localparam logic [7:0] CHAR_NINE  = "9";

  localparam logic [31:0] TIMEOUT_RESET_MS = 32'd5000;

  // command table rows: auto (prefix match), manual, pause, estop
  localparam logic [1:0] CMD_AUTO   = 2'd0;
  localparam logic [1:0] CMD_MANUAL = 2'd1;
  localparam logic [1:0] CMD_PAUSE  = 2'd2;
  localparam logic [1:0] CMD_ESTOP  = 2'd3;

  localparam int unsigned CMD_COUNT = 4;
  localparam int unsigned POS_W     = 4;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [POS_W-1:0] CMD_LEN  [CMD_COUNT] = '{4'd8, 4'd10, 4'd9, 4'd9};
  localparam logic [2:0]       CMD_CODE [CMD_COUNT] =
    '{CODE_AUTO, CODE_MANUAL, CODE_PAUSE, CODE_ESTOP};

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CMD_C    = 4'd1,
    PH_S_COLON  = 4'd2,
    PH_S_FIRST  = 4'd3,
    PH_S_DIGITS = 4'd4,
    PH_CMD_S    = 4'd5,
    PH_NOSEQ    = 4'd6
  } phase_t;

  typedef struct packed {
    logic        frame_done;
    logic        command_accepted;
    logic [2:0]  command_code;
    logic        sequence_gap;
    logic [31:0] gap_total;
    logic [31:0] frame_total;
    logic [31:0] raw_frame_total;
    logic        pending_flag;
    logic        timeout_discard;
  } lcfp_result_t;

  // "CMD:" head shared by every command
  function automatic logic [7:0] cmd_head(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = "C";
      2'd1:    c = "M";
      2'd2:    c = "D";
      default: c = ":";
    endcase
    return c;
  endfunction

  // character of command row k at text position pos (pos below that row's length)
  function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [POS_W-1:0] pos);
    logic [7:0] c;
    c = CHAR_NUL;
    if (pos < 4'd4) begin
      c = cmd_head(pos[1:0]);
    end else begin
      case (k)
        CMD_AUTO: begin
          case (pos)
            4'd4:    c = "A";
            4'd5:    c = "U";
            4'd6:    c = "T";
            4'd7:    c = "O";
            default: c = CHAR_NUL;
          endcase
        end
        CMD_MANUAL: begin
          case (pos)
            4'd4:    c = "M";
            4'd5:    c = "A";
            4'd6:    c = "N";
            4'd7:    c = "U";
            4'd8:    c = "A";
            4'd9:    c = "L";
            default: c = CHAR_NUL;
          endcase
        end
        CMD_PAUSE: begin
          case (pos)
            4'd4:    c = "P";
            4'd5:    c = "A";
            4'd6:    c = "U";
            4'd7:    c = "S";
            4'd8:    c = "E";
            default: c = CHAR_NUL;
          endcase
        end
        default: begin
          case (pos)
            4'd4:    c = "E";
            4'd5:    c = "S";
            4'd6:    c = "T";
            4'd7:    c = "O";
            4'd8:    c = "P";
            default: c = CHAR_NUL;
          endcase
        end
      endcase
    end
    return c;
  endfunction

endpackage

[hw/rtl/lcfp_core.sv]
// lcfp_core: frame state, sequence check, command match and counters, one accepted beat per cycle
// depends on lcfp_pkg
module lcfp_core #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           operation,
  input  logic [7:0]           data_byte,
  input  logic [31:0]          now_ms,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  output lcfp_pkg::lcfp_result_t result
);
  import lcfp_pkg::*;

  localparam int LEN_W = $clog2(BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(BUFFER_BYTES - 1);

  logic [31:0]      timeout_ms;
  logic [LEN_W-1:0] raw_length, raw_length_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  phase_t           parse_phase, parse_phase_next;
  logic [31:0]      sequence_value, sequence_value_next;
  logic [3:0]       match_flags, match_flags_next;
  logic [POS_W-1:0] text_position, text_position_next;
  logic             text_ended, text_ended_next;
  logic             sequence_started, sequence_started_next;
  logic [31:0]      expected_sequence, expected_sequence_next;
  logic [31:0]      gap_counter, gap_counter_next;
  logic [31:0]      frame_counter, frame_counter_next;
  logic [31:0]      raw_counter, raw_counter_next;
  logic             pending_valid, pending_valid_next;
  logic [2:0]       pending_code, pending_code_next;
  logic [31:0]      last_frame_time, last_frame_time_next;

  logic             is_eol, is_digit, is_start;
  logic [35:0]      seq_mul;
  logic [31:0]      seq_sat;
  logic [3:0]       fed_flags;
  logic [POS_W-1:0] pos_inc;
  logic             frame_close, seq_check, gap_hit, in_cmd;
  logic [3:0]       row_hit;
  logic             cmd_hit;
  logic [2:0]       hit_code;
  logic [31:0]      elapsed;
  logic             discard, fetch_hit;

  assign is_eol   = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign is_start = (data_byte == CHAR_C) || (data_byte == CHAR_S);

  // times ten plus digit, clamped to all ones
  assign seq_mul = ({4'd0, sequence_value} << 3) + ({4'd0, sequence_value} << 1)
                 + {32'd0, data_byte[3:0]};
  assign seq_sat = (seq_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : seq_mul[31:0];

  // position saturates well past the longest command, compares stay exact
  assign pos_inc = (text_position == POS_MAX) ? POS_MAX : text_position + POS_W'(1);

  always_comb begin
    for (int k = 0; k < CMD_COUNT; k++) begin
      if (text_position < CMD_LEN[k]) begin
        fed_flags[k] = match_flags[k] && (data_byte == cmd_char(2'(k), text_position));
      end else begin
        fed_flags[k] = match_flags[k] && (k == 0);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CMD_COUNT; k++) begin
      if (k == 0) begin
        row_hit[k] = match_flags[k] && (text_position >= CMD_LEN[k]);
      end else begin
        row_hit[k] = match_flags[k] && (text_position == CMD_LEN[k]);
      end
    end
  end

  assign in_cmd      = (parse_phase == PH_CMD_C) || (parse_phase == PH_CMD_S);
  assign frame_close = (operation == OP_BYTE) && is_eol && (frame_length != '0);
  assign seq_check   = frame_close && (parse_phase == PH_CMD_S);
  assign gap_hit     = seq_check && sequence_started && (sequence_value != expected_sequence);
  assign cmd_hit     = frame_close && in_cmd && (row_hit != 4'd0);

  always_comb begin
    if (row_hit[CMD_AUTO]) begin
      hit_code = CMD_CODE[CMD_AUTO];
    end else if (row_hit[CMD_MANUAL]) begin
      hit_code = CMD_CODE[CMD_MANUAL];
    end else if (row_hit[CMD_PAUSE]) begin
      hit_code = CMD_CODE[CMD_PAUSE];
    end else begin
      hit_code = CMD_CODE[CMD_ESTOP];
    end
  end

  assign elapsed   = now_ms - last_frame_time;
  assign discard   = (operation == OP_TIME) && (frame_length != '0) && (elapsed > timeout_ms);
  assign fetch_hit = (operation == OP_FETCH) && pending_valid;

  // next state
  always_comb begin
    raw_length_next        = raw_length;
    frame_length_next      = frame_length;
    parse_phase_next       = parse_phase;
    sequence_value_next    = sequence_value;
    match_flags_next       = match_flags;
    text_position_next     = text_position;
    text_ended_next        = text_ended;
    sequence_started_next  = sequence_started;
    expected_sequence_next = expected_sequence;
    gap_counter_next       = gap_counter;
    frame_counter_next     = frame_counter;
    raw_counter_next       = raw_counter;
    pending_valid_next     = pending_valid;
    pending_code_next      = pending_code;
    last_frame_time_next   = last_frame_time;

    if (accept) begin
      unique case (operation)
        OP_BYTE: begin
          if (is_eol) begin
            if (raw_length != '0) begin
              raw_counter_next = raw_counter + 32'd1;
              raw_length_next  = '0;
            end
            if (frame_close) begin
              last_frame_time_next = now_ms;
              frame_counter_next   = frame_counter + 32'd1;
              pending_valid_next   = cmd_hit;
              if (cmd_hit) begin
                pending_code_next = hit_code;
              end
              if (seq_check) begin
                sequence_started_next  = 1'b1;
                expected_sequence_next = sequence_value + 32'd1;
              end
              if (gap_hit) begin
                gap_counter_next = gap_counter + 32'd1;
              end
              frame_length_next = '0;
              parse_phase_next  = PH_IDLE;
            end
          end else begin
            raw_length_next = (raw_length < LEN_LAST) ? raw_length + LEN_W'(1) : '0;
            if (frame_length == '0) begin
              if (is_start) begin
                text_ended_next     = 1'b0;
                sequence_value_next = '0;
                frame_length_next   = LEN_W'(1);
                if (data_byte == CHAR_C) begin
                  // the 'C' itself already matches every row
                  parse_phase_next   = PH_CMD_C;
                  match_flags_next   = 4'hF;
                  text_position_next = POS_W'(1);
                end else begin
                  parse_phase_next   = PH_S_COLON;
                  match_flags_next   = 4'h0;
                  text_position_next = '0;
                end
              end
            end else if (parse_phase == PH_CMD_C && frame_length <= LEN_W'(3) &&
                         data_byte != cmd_head(frame_length[1:0])) begin
              frame_length_next = '0;
              parse_phase_next  = PH_IDLE;
            end else if (frame_length < LEN_LAST) begin
              frame_length_next = frame_length + LEN_W'(1);
              if (!text_ended) begin
                if (data_byte == CHAR_NUL) begin
                  text_ended_next = 1'b1;
                end else begin
                  unique case (parse_phase)
                    PH_CMD_C, PH_CMD_S: begin
                      match_flags_next   = fed_flags;
                      text_position_next = pos_inc;
                    end
                    PH_S_COLON: begin
                      parse_phase_next = (data_byte == CHAR_COLON) ? PH_S_FIRST : PH_NOSEQ;
                    end
                    PH_S_FIRST: begin
                      if (is_digit) begin
                        sequence_value_next = {28'd0, data_byte[3:0]};
                        parse_phase_next    = PH_S_DIGITS;
                      end else begin
                        parse_phase_next = PH_NOSEQ;
                      end
                    end
                    PH_S_DIGITS: begin
                      if (is_digit) begin
                        sequence_value_next = seq_sat;
                      end else if (data_byte == CHAR_COLON) begin
                        parse_phase_next   = PH_CMD_S;
                        match_flags_next   = 4'hF;
                        text_position_next = '0;
                      end else begin
                        parse_phase_next = PH_NOSEQ;
                      end
                    end
                    default: begin
                    end
                  endcase
                end
              end
            end else begin
              frame_length_next = '0;
              parse_phase_next  = PH_IDLE;
            end
          end
        end
        OP_TIME: begin
          if (discard) begin
            frame_length_next = '0;
            parse_phase_next  = PH_IDLE;
          end
        end
        OP_FETCH: begin
          if (pending_valid) begin
            pending_valid_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result of the beat being accepted
  always_comb begin
    result                  = '0;
    result.frame_done       = frame_close;
    result.command_accepted = cmd_hit;
    if (cmd_hit) begin
      result.command_code = hit_code;
    end else if (fetch_hit) begin
      result.command_code = pending_code;
    end else begin
      result.command_code = CODE_MANUAL;
    end
    result.sequence_gap     = gap_hit;
    result.gap_total        = gap_counter_next;
    result.frame_total      = frame_counter_next;
    result.raw_frame_total  = raw_counter_next;
    result.pending_flag     = fetch_hit;
    result.timeout_discard  = discard;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET_MS;
    end else if (cfg_we) begin
      timeout_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_length        <= '0;
      frame_length      <= '0;
      parse_phase       <= PH_IDLE;
      sequence_value    <= '0;
      match_flags       <= '0;
      text_position     <= '0;
      text_ended        <= 1'b0;
      sequence_started  <= 1'b0;
      expected_sequence <= '0;
      gap_counter       <= '0;
      frame_counter     <= '0;
      raw_counter       <= '0;
      pending_valid     <= 1'b0;
      pending_code      <= '0;
      last_frame_time   <= '0;
    end else begin
      raw_length        <= raw_length_next;
      frame_length      <= frame_length_next;
      parse_phase       <= parse_phase_next;
      sequence_value    <= sequence_value_next;
      match_flags       <= match_flags_next;
      text_position     <= text_position_next;
      text_ended        <= text_ended_next;
      sequence_started  <= sequence_started_next;
      expected_sequence <= expected_sequence_next;
      gap_counter       <= gap_counter_next;
      frame_counter     <= frame_counter_next;
      raw_counter       <= raw_counter_next;
      pending_valid     <= pending_valid_next;
      pending_code      <= pending_code_next;
      last_frame_time   <= last_frame_time_next;
    end
  end

endmodule

[hw/rtl/lcfp_out_buf.sv]
// lcfp_out_buf: result register with a skid stage behind it
// depends on lcfp_pkg
module lcfp_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lcfp_pkg::lcfp_result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lcfp_pkg::lcfp_result_t out_data
);
  import lcfp_pkg::*;

  lcfp_result_t skid_data;
  logic         skid_valid;
  logic         take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

[hw/rtl/line_command_frame_parser_top.sv]
// line_command_frame_parser_top: line/command frame parser, state core plus output buffer
// depends on lcfp_pkg, lcfp_core, lcfp_out_buf
//
//  channel  handshake              payload
//  in       in_valid / in_stall    operation, data_byte, now_ms
//  out      out_valid / out_stall  frame_done .. timeout_discard
//  cfg      cfg_valid / cfg_ready  cfg_data (timeout_ms)
//
// one beat per cycle while in_stall is low; each input beat is fully handled in
// the cycle it is taken; its result goes to the result register or the skid stage
// in_stall rises only when the result register and the skid stage both hold beats
// cfg_ready is always high; rst is synchronous and restores timeout_ms to 5000
module line_command_frame_parser_top #(
  parameter int BUFFER_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic [31:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_done,
  output logic        command_accepted,
  output logic [2:0]  command_code,
  output logic        sequence_gap,
  output logic [31:0] gap_total,
  output logic [31:0] frame_total,
  output logic [31:0] raw_frame_total,
  output logic        pending_flag,
  output logic        timeout_discard
);
  import lcfp_pkg::*;

  lcfp_result_t step_result;
  lcfp_result_t held_result;
  logic         accept;
  logic         buf_full;

  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lcfp_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .data_byte (data_byte),
    .now_ms    (now_ms),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (step_result)
  );

  lcfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (held_result)
  );

  assign frame_done       = held_result.frame_done;
  assign command_accepted = held_result.command_accepted;
  assign command_code     = held_result.command_code;
  assign sequence_gap     = held_result.sequence_gap;
  assign gap_total        = held_result.gap_total;
  assign frame_total      = held_result.frame_total;
  assign raw_frame_total  = held_result.raw_frame_total;
  assign pending_flag     = held_result.pending_flag;
  assign timeout_discard  = held_result.timeout_discard;

endmodule
